// ----- hw/rtl/lr_pkg.sv -----
// Shared constants and types for the line rasterizer.
`default_nettype none
package lr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COLOR_BITS     = 8;
    // Extra bits on top of the coordinate width for the signed error term.
    localparam int ERR_EXT_BITS   = 4;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Octant cases
    localparam logic [1:0] OCT_SHALLOW_RISE = 2'd0;
    localparam logic [1:0] OCT_STEEP_RISE   = 2'd1;
    localparam logic [1:0] OCT_STEEP_FALL   = 2'd2;
    localparam logic [1:0] OCT_SHALLOW_FALL = 2'd3;

    typedef struct packed {
        logic emit;    // current beat produces a pixel
        logic last;    // that pixel is the line's endpoint
        logic active;  // a line is loaded with pixels still to go
    } t_lr_flags;

endpackage
`default_nettype wire

// ----- hw/rtl/lr_core.sv -----
// Bresenham line state and per-beat pixel computation.
`default_nettype none
module lr_core #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire logic                          i_cmd,
    input  wire logic [COORD_BITS-1:0]         i_start_x,
    input  wire logic [COORD_BITS-1:0]         i_start_y,
    input  wire logic [COORD_BITS-1:0]         i_end_x,
    input  wire logic [COORD_BITS-1:0]         i_end_y,
    input  wire logic [lr_pkg::COLOR_BITS-1:0] i_red,
    input  wire logic [lr_pkg::COLOR_BITS-1:0] i_green,
    input  wire logic [lr_pkg::COLOR_BITS-1:0] i_blue,
    output logic [COORD_BITS-1:0]              o_x,
    output logic [COORD_BITS-1:0]              o_y,
    output logic [lr_pkg::COLOR_BITS-1:0]      o_red,
    output logic [lr_pkg::COLOR_BITS-1:0]      o_green,
    output logic [lr_pkg::COLOR_BITS-1:0]      o_blue,
    output lr_pkg::t_lr_flags                  o_flags
);
    import lr_pkg::*;

    localparam int DW = COORD_BITS + ERR_EXT_BITS;

    logic [COORD_BITS-1:0]   r_cur_x, r_cur_y, r_steps;
    logic signed [DW-1:0]    r_dec, r_d_str, r_d_diag;
    logic [1:0]              r_oct;
    logic [COLOR_BITS-1:0]   r_red, r_green, r_blue;
    logic                    r_active;

    logic [COORD_BITS-1:0]   n_cur_x, n_cur_y, n_steps;
    logic signed [DW-1:0]    n_dec, n_d_str, n_d_diag;
    logic [1:0]              n_oct;

    // load path
    logic                    swap, dy_neg, steep;
    logic [COORD_BITS-1:0]   lx, ly, hx, hy, dx, ady;
    logic signed [DW-1:0]    dxs, dys, dx2, dy2;

    // step path
    logic                    neg, diag;
    logic [COORD_BITS-1:0]   st_x, st_y, st_steps;

    always_comb begin
        swap = (i_start_x > i_end_x) || ((i_start_x == i_end_x) && (i_start_y > i_end_y));
        lx   = swap ? i_end_x   : i_start_x;
        ly   = swap ? i_end_y   : i_start_y;
        hx   = swap ? i_start_x : i_end_x;
        hy   = swap ? i_start_y : i_end_y;
        dx     = hx - lx;
        dy_neg = hy < ly;
        ady    = dy_neg ? (ly - hy) : (hy - ly);
        steep  = ady >= dx;
        dxs = signed'({{ERR_EXT_BITS{1'b0}}, dx});
        dys = dy_neg ? -signed'({{ERR_EXT_BITS{1'b0}}, ady})
                     :  signed'({{ERR_EXT_BITS{1'b0}}, ady});
        dx2 = dxs <<< 1;
        dy2 = dys <<< 1;
    end

    always_comb begin
        neg  = r_dec[DW-1];
        st_x = r_cur_x;
        st_y = r_cur_y;
        case (r_oct)
            OCT_SHALLOW_RISE: begin
                diag = !neg;
                st_x = r_cur_x + 1'b1;
                if (diag) st_y = r_cur_y + 1'b1;
            end
            OCT_STEEP_RISE: begin
                diag = neg;
                st_y = r_cur_y + 1'b1;
                if (diag) st_x = r_cur_x + 1'b1;
            end
            OCT_STEEP_FALL: begin
                diag = !neg;
                st_y = r_cur_y - 1'b1;
                if (diag) st_x = r_cur_x + 1'b1;
            end
            default: begin
                diag = neg;
                st_x = r_cur_x + 1'b1;
                if (diag) st_y = r_cur_y - 1'b1;
            end
        endcase
        st_steps = r_steps - 1'b1;
    end

    always_comb begin
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_steps  = r_steps;
        n_dec    = r_dec;
        n_d_str  = r_d_str;
        n_d_diag = r_d_diag;
        n_oct    = r_oct;
        if (i_cmd == CMD_LOAD) begin
            n_cur_x = lx;
            n_cur_y = ly;
            if (!dy_neg) begin
                if (steep) begin
                    n_oct    = OCT_STEEP_RISE;
                    n_dec    = dys - dx2;
                    n_d_str  = -dx2;
                    n_d_diag = dy2 - dx2;
                    n_steps  = ady;
                end else begin
                    n_oct    = OCT_SHALLOW_RISE;
                    n_dec    = dy2 - dxs;
                    n_d_str  = dy2;
                    n_d_diag = dy2 - dx2;
                    n_steps  = dx;
                end
            end else begin
                if (steep) begin
                    n_oct    = OCT_STEEP_FALL;
                    n_dec    = dys + dx2;
                    n_d_str  = dx2;
                    n_d_diag = dy2 + dx2;
                    n_steps  = ady;
                end else begin
                    n_oct    = OCT_SHALLOW_FALL;
                    n_dec    = dy2 + dxs;
                    n_d_str  = dy2;
                    n_d_diag = dy2 + dx2;
                    n_steps  = dx;
                end
            end
        end else if (r_active) begin
            n_cur_x = st_x;
            n_cur_y = st_y;
            n_steps = st_steps;
            n_dec   = r_dec + (diag ? r_d_diag : r_d_str);
        end
    end

    always_comb begin
        o_flags.emit   = (i_cmd == CMD_LOAD) || r_active;
        o_flags.last   = (n_steps == '0);
        o_flags.active = r_active;
        o_x = n_cur_x;
        o_y = n_cur_y;
        if (i_cmd == CMD_LOAD) begin
            o_red   = i_red;
            o_green = i_green;
            o_blue  = i_blue;
        end else begin
            o_red   = r_red;
            o_green = r_green;
            o_blue  = r_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_steps  <= '0;
            r_dec    <= '0;
            r_d_str  <= '0;
            r_d_diag <= '0;
            r_oct    <= OCT_SHALLOW_RISE;
            r_red    <= '0;
            r_green  <= '0;
            r_blue   <= '0;
            r_active <= 1'b0;
        end else if (i_fire && ((i_cmd == CMD_LOAD) || r_active)) begin
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_steps  <= n_steps;
            r_dec    <= n_dec;
            r_d_str  <= n_d_str;
            r_d_diag <= n_d_diag;
            r_oct    <= n_oct;
            r_red    <= o_red;
            r_green  <= o_green;
            r_blue   <= o_blue;
            r_active <= (n_steps != '0);
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/line_rasterizer.sv -----
// Top level of the Bresenham line rasterizer.
// A load beat (cmd 0) takes two endpoints and a color and produces the first
// pixel; each step beat (cmd 1) produces the next pixel of the line, with
// last_pixel set on the endpoint. A step with no line loaded produces nothing,
// and a load replaces any line in progress. A beat goes through the input
// register, then the pixel register; the block sustains one beat per clock
// while no output stall holds it: the line state update is a single add and
// compare per cycle. The input stall follows the output stall only while the
// pixel register holds a beat that has not been taken.
`default_nettype none
module line_rasterizer #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_cmd,
    input  wire logic [COORD_BITS-1:0]         i_start_x,
    input  wire logic [COORD_BITS-1:0]         i_start_y,
    input  wire logic [COORD_BITS-1:0]         i_end_x,
    input  wire logic [COORD_BITS-1:0]         i_end_y,
    input  wire logic [lr_pkg::COLOR_BITS-1:0] i_red_in,
    input  wire logic [lr_pkg::COLOR_BITS-1:0] i_green_in,
    input  wire logic [lr_pkg::COLOR_BITS-1:0] i_blue_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [COORD_BITS-1:0]              o_pixel_x,
    output logic [COORD_BITS-1:0]              o_pixel_y,
    output logic [lr_pkg::COLOR_BITS-1:0]      o_red_out,
    output logic [lr_pkg::COLOR_BITS-1:0]      o_green_out,
    output logic [lr_pkg::COLOR_BITS-1:0]      o_blue_out,
    output logic                               o_last_pixel
);
    import lr_pkg::*;

    logic                  r_s1_valid, r_s1_cmd;
    logic [COORD_BITS-1:0] r_s1_sx, r_s1_sy, r_s1_ex, r_s1_ey;
    logic [COLOR_BITS-1:0] r_s1_red, r_s1_green, r_s1_blue;

    logic                  r_out_valid, r_out_last;
    logic [COORD_BITS-1:0] r_out_x, r_out_y;
    logic [COLOR_BITS-1:0] r_out_red, r_out_green, r_out_blue;

    logic                  out_free, s1_move;
    logic [COORD_BITS-1:0] px, py;
    logic [COLOR_BITS-1:0] pr, pg, pb;
    t_lr_flags             flags;

    lr_core #(
        .COORD_BITS(COORD_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (s1_move),
        .i_cmd     (r_s1_cmd),
        .i_start_x (r_s1_sx),
        .i_start_y (r_s1_sy),
        .i_end_x   (r_s1_ex),
        .i_end_y   (r_s1_ey),
        .i_red     (r_s1_red),
        .i_green   (r_s1_green),
        .i_blue    (r_s1_blue),
        .o_x       (px),
        .o_y       (py),
        .o_red     (pr),
        .o_green   (pg),
        .o_blue    (pb),
        .o_flags   (flags)
    );

    // a beat with no pixel can drain even when the pixel register is full
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && (out_free || !flags.emit);
    assign o_in_stall = r_s1_valid && !s1_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_cmd   <= i_cmd;
            r_s1_sx    <= i_start_x;
            r_s1_sy    <= i_start_y;
            r_s1_ex    <= i_end_x;
            r_s1_ey    <= i_end_y;
            r_s1_red   <= i_red_in;
            r_s1_green <= i_green_in;
            r_s1_blue  <= i_blue_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_move && flags.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s1_move && flags.emit) begin
            r_out_x     <= px;
            r_out_y     <= py;
            r_out_red   <= pr;
            r_out_green <= pg;
            r_out_blue  <= pb;
            r_out_last  <= flags.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_out_x;
    assign o_pixel_y    = r_out_y;
    assign o_red_out    = r_out_red;
    assign o_green_out  = r_out_green;
    assign o_blue_out   = r_out_blue;
    assign o_last_pixel = r_out_last;

`ifndef SYNTHESIS
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with empty input register");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && flags.emit && flags.last) |=> !flags.active)
        else $error("line still active after its last pixel");

    a_silent_only_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && !flags.emit) |-> (r_s1_cmd == CMD_STEP && !flags.active))
        else $error("beat dropped without a pixel while a line was active");
`endif

endmodule
`default_nettype wire
